/* rtl/psc_pkg.sv */
// Shared widths, register indexes and configuration struct for the PID speed controller.
package psc_pkg;

  localparam int OPA_W  = 25;
  localparam int OPB_W  = 33;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int NF_W   = 50;
  localparam int RAW_W  = 26;
  localparam int DRV_W  = 13;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_KP          = 3'd0;
  localparam logic [2:0] REG_KI_DT       = 3'd1;
  localparam logic [2:0] REG_KD_DT       = 3'd2;
  localparam logic [2:0] REG_FF_A        = 3'd3;
  localparam logic [2:0] REG_FF_B        = 3'd4;
  localparam logic [2:0] REG_DEAD_ZONE   = 3'd5;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd6;
  localparam logic [2:0] REG_OUT_LIMIT   = 3'd7;

  typedef logic signed [OPA_W-1:0]  opa_t;
  typedef logic signed [OPB_W-1:0]  opb_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [23:0]        kp;
    logic [23:0]        ki_dt;
    logic [23:0]        kd_dt;
    logic signed [23:0] ff_a;
    logic signed [23:0] ff_b;
    logic [11:0]        dead_zone;
    logic [30:0]        integ_limit;
    logic [11:0]        out_limit;
  } cfg_t;

endpackage

/* rtl/psc_regs.sv */
// APB-style configuration register file for the PID speed controller.
module psc_regs import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_KP:          cfg_nxt.kp          = pwdata[23:0];
        REG_KI_DT:       cfg_nxt.ki_dt       = pwdata[23:0];
        REG_KD_DT:       cfg_nxt.kd_dt       = pwdata[23:0];
        REG_FF_A:        cfg_nxt.ff_a        = pwdata[23:0];
        REG_FF_B:        cfg_nxt.ff_b        = pwdata[23:0];
        REG_DEAD_ZONE:   cfg_nxt.dead_zone   = pwdata[11:0];
        REG_INTEG_LIMIT: cfg_nxt.integ_limit = pwdata[30:0];
        REG_OUT_LIMIT:   cfg_nxt.out_limit   = pwdata[11:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP:          prdata = {8'd0, cfg_r.kp};
      REG_KI_DT:       prdata = {8'd0, cfg_r.ki_dt};
      REG_KD_DT:       prdata = {8'd0, cfg_r.kd_dt};
      REG_FF_A:        prdata = {{8{cfg_r.ff_a[23]}}, cfg_r.ff_a};
      REG_FF_B:        prdata = {{8{cfg_r.ff_b[23]}}, cfg_r.ff_b};
      REG_DEAD_ZONE:   prdata = {20'd0, cfg_r.dead_zone};
      REG_INTEG_LIMIT: prdata = {1'b0, cfg_r.integ_limit};
      REG_OUT_LIMIT:   prdata = {20'd0, cfg_r.out_limit};
      default:         prdata = '0;
    endcase
  end

  // out_limit is the low field and resets to 4095, all others to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_t'({{($bits(cfg_t)-12){1'b0}}, 12'hFFF});
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/psc_mul.sv */
// Shared signed multiplier with registered product.
module psc_mul import psc_pkg::*; (
  input  logic  clk,
  input  opa_t  op_a,
  input  opb_t  op_b,
  output prod_t prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

/* rtl/pid_speed_controller_core.sv */
// PID speed controller top level: sequencer, state and datapath around one shared multiplier.
// A compute transfer is accepted only in the idle state, so a new item waits until the previous
// result has been passed on; each item takes six multiplications on the single 25x33 multiplier
// plus filter, integrator, rounding and saturation steps, and the output state waits on out_ready.
// A reset command (cmd = 1) clears the state and produces no result.
// rst_n (synchronous) clears state, sequencer and config (out_limit to 4095).
module pid_speed_controller_core import psc_pkg::*; #(
  parameter int FILTER_ALPHA = 16384
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic signed [15:0]      in_setpoint,
  input  logic signed [15:0]      in_measurement,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DRV_W-1:0] out_drive,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam opa_t ALPHA_A = opa_t'(FILTER_ALPHA);
  localparam opa_t ALPHA_B = opa_t'(65536 - FILTER_ALPHA);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_A    = 4'd1;
  localparam logic [3:0] S_MUL_B    = 4'd2;
  localparam logic [3:0] S_MUL_KI   = 4'd3;
  localparam logic [3:0] S_MUL_KP   = 4'd4;
  localparam logic [3:0] S_MUL_KD   = 4'd5;
  localparam logic [3:0] S_MUL_FF   = 4'd6;
  localparam logic [3:0] S_ADD_FF   = 4'd7;
  localparam logic [3:0] S_ADD_I    = 4'd8;
  localparam logic [3:0] S_ROUND    = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  cfg_t cfg;

  logic [3:0]               st_r;
  logic [3:0]               st_nxt;
  logic                     in_xfer;
  logic                     out_free;
  logic                     out_valid_r;

  logic signed [15:0]       sp_r;
  logic signed [15:0]       meas_r;
  logic signed [15:0]       last_meas_r;
  logic signed [16:0]       err_r;
  logic signed [16:0]       d_r;
  logic signed [31:0]       filt_r;
  logic signed [31:0]       integ_r;
  logic signed [NF_W-1:0]   nf_r;
  logic signed [33:0]       inc_r;
  logic signed [PROD_W-1:0] sum_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic signed [DRV_W-1:0]  drive_r;

  opa_t                     op_a;
  opb_t                     op_b;
  prod_t                    prod_r;

  logic signed [NF_W-1:0]   nf_rnd;
  logic signed [PROD_W-1:0] inc_rnd;
  logic signed [34:0]       ia;
  logic signed [34:0]       lim;
  logic signed [34:0]       ia_clamp;
  logic signed [PROD_W-1:0] ffb_term;
  logic signed [PROD_W-1:0] kp_term;
  logic signed [PROD_W-1:0] ff_term;
  logic signed [PROD_W-1:0] integ_term;
  logic signed [PROD_W-1:0] sum_rnd;
  logic signed [RAW_W:0]    dz_adj;
  logic signed [RAW_W:0]    ol;
  logic signed [DRV_W-1:0]  drive_nxt;

  psc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psc_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign in_ready  = (st_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_drive = drive_r;

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (st_r)
      S_MUL_A: begin
        op_a = ALPHA_A;
        op_b = {{(OPB_W-17){d_r[16]}}, d_r};
      end
      S_MUL_B: begin
        op_a = ALPHA_B;
        op_b = {filt_r[31], filt_r};
      end
      S_MUL_KI: begin
        op_a = {1'b0, cfg.ki_dt};
        op_b = {{(OPB_W-17){err_r[16]}}, err_r};
      end
      S_MUL_KP: begin
        op_a = {1'b0, cfg.kp};
        op_b = {{(OPB_W-17){err_r[16]}}, err_r};
      end
      S_MUL_KD: begin
        op_a = {1'b0, cfg.kd_dt};
        op_b = {filt_r[31], filt_r};
      end
      S_MUL_FF: begin
        op_a = {cfg.ff_a[23], cfg.ff_a};
        op_b = {{(OPB_W-16){sp_r[15]}}, sp_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // round half away from zero: add half, or half minus one when negative, then shift
  assign nf_rnd  = nf_r + (nf_r[NF_W-1] ? NF_W'(32'h7FFF) : NF_W'(32'h8000));
  assign inc_rnd = prod_r + (prod_r[PROD_W-1] ? PROD_W'(8'd127) : PROD_W'(9'd128));
  assign sum_rnd = sum_r + (sum_r[PROD_W-1] ? PROD_W'(32'h7FFF_FFFF) : PROD_W'(32'h8000_0000));

  assign ia  = {{3{integ_r[31]}}, integ_r} + {inc_r[33], inc_r};
  assign lim = {4'd0, cfg.integ_limit};

  always_comb begin
    ia_clamp = ia;
    if (ia > lim) begin
      ia_clamp = lim;
    end else if (ia < -lim) begin
      ia_clamp = -lim;
    end
  end

  assign ffb_term   = {{(PROD_W-48){cfg.ff_b[23]}}, cfg.ff_b, 24'd0};
  assign kp_term    = {prod_r[PROD_W-9:0], 8'd0};
  assign ff_term    = {prod_r[PROD_W-9:0], 8'd0};
  assign integ_term = {{(PROD_W-48){integ_r[31]}}, integ_r, 16'd0};

  assign ol = {{(RAW_W+1-12){1'b0}}, cfg.out_limit};

  always_comb begin
    if (raw_r > 0) begin
      dz_adj = {raw_r[RAW_W-1], raw_r} + {{(RAW_W+1-12){1'b0}}, cfg.dead_zone};
    end else if (raw_r < 0) begin
      dz_adj = {raw_r[RAW_W-1], raw_r} - {{(RAW_W+1-12){1'b0}}, cfg.dead_zone};
    end else begin
      dz_adj = '0;
    end
    if (dz_adj > ol) begin
      drive_nxt = DRV_W'(ol);
    end else if (dz_adj < -ol) begin
      drive_nxt = DRV_W'(-ol);
    end else begin
      drive_nxt = DRV_W'(dz_adj);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:   if (in_xfer && !in_cmd) st_nxt = S_MUL_A;
      S_MUL_A:  st_nxt = S_MUL_B;
      S_MUL_B:  st_nxt = S_MUL_KI;
      S_MUL_KI: st_nxt = S_MUL_KP;
      S_MUL_KP: st_nxt = S_MUL_KD;
      S_MUL_KD: st_nxt = S_MUL_FF;
      S_MUL_FF: st_nxt = S_ADD_FF;
      S_ADD_FF: st_nxt = S_ADD_I;
      S_ADD_I:  st_nxt = S_ROUND;
      S_ROUND:  st_nxt = S_OUT;
      S_OUT:    if (out_free) st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      last_meas_r <= '0;
      filt_r      <= '0;
      integ_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer && in_cmd) begin
        last_meas_r <= '0;
        filt_r      <= '0;
        integ_r     <= '0;
      end else begin
        if (st_r == S_MUL_B) last_meas_r <= meas_r;
        if (st_r == S_MUL_KP) filt_r <= nf_rnd[47:16];
        if (st_r == S_MUL_KD) integ_r <= ia_clamp[31:0];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sp_r   <= in_setpoint;
      meas_r <= in_measurement;
      err_r  <= {in_setpoint[15], in_setpoint} - {in_measurement[15], in_measurement};
      d_r    <= {in_measurement[15], in_measurement} - {last_meas_r[15], last_meas_r};
    end
    unique case (st_r)
      S_MUL_A: begin
        if (sp_r > 0) begin
          sum_r <= ffb_term;
        end else if (sp_r < 0) begin
          sum_r <= -ffb_term;
        end else begin
          sum_r <= '0;
        end
      end
      S_MUL_B:  nf_r  <= {prod_r[NF_W-9:0], 8'd0};
      S_MUL_KI: nf_r  <= nf_r + prod_r[NF_W-1:0];
      S_MUL_KP: inc_r <= inc_rnd[41:8];
      S_MUL_KD: sum_r <= sum_r + kp_term;
      S_MUL_FF: sum_r <= sum_r - prod_r;
      S_ADD_FF: sum_r <= sum_r + ff_term;
      S_ADD_I:  sum_r <= sum_r + integ_term;
      S_ROUND:  raw_r <= sum_rnd[PROD_W-1:32];
      S_OUT:    if (out_free) drive_r <= drive_nxt;
      default:  ;
    endcase
  end

endmodule
